FILE: rtl/pmst_pkg.sv
// Shared types and constants for the Prim spanning tree unit.
package pmst_pkg;

    // Fixed widths of the port fields.
    localparam int ROW_W     = 4;
    localparam int WEIGHT_W  = 16;
    localparam int VC_W      = 5;
    localparam int TOTAL_W   = 20;

    // Vertex counters hold the vertex count itself, so they need one bit more than an index.
    localparam int CNT_W     = 5;

    // The vertex count in use never exceeds this, whatever the storage size.
    localparam int VTX_LIMIT = 16;

    localparam logic [VC_W-1:0]    VC_RESET  = 5'd16;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_SEL,
        ST_TAKE,
        ST_REL_RD,
        ST_REL_UPD,
        ST_EM_CHK,
        ST_EM_ADD,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctrl_t;

endpackage

FILE: rtl/pmst_matrix_ram.sv
// Adjacency matrix store: one write port, one registered read port.
module pmst_matrix_ram
    import pmst_pkg::*;
#(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 16
)
(
    input  logic              clk,
    input  ram_ctrl_t         ctrl,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read data holds until the next read strobe.
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/prim_minimum_spanning_tree_unit.sv
// Prim minimum spanning tree unit: matrix loading, tree search and edge list output.
//
//   Channel   Handshake              Word carried
//   -------   --------------------   ---------------------------------------------------
//   input     in_valid / in_stall    row, col, weight, last_entry (one matrix entry)
//   output    out_valid / out_stall  from_vertex, to_vertex, edge_weight, total_cost,
//                                    is_total, disconnected, last
//   config    cfg_we / cfg_wdata     vertex_count, written while the unit is idle
//
// Matrix entries are taken one per cycle while the unit is loading. The word that carries
// last_entry starts a run: a set-up step, then for each of the R vertices reached a search
// pass over the V vertices, a step to take the vertex and a key relaxation pass over them
// (one matrix read and one compare per vertex), and finally a search pass that finds
// nothing plus a step to see that. Every compare goes through the one shared comparator.
// The edge list then checks each vertex above vertex 0 in turn, with a further step that
// emits the edge word of each reached vertex, and ends with the summary word, each output
// word also waiting for the output register to be free.
// in_stall stays high from the last entry until the summary word has been loaded into the
// output register; the next matrix may start loading while that word waits to be taken.
// A stall on the output simply holds the sequencer at the next output word.
// Reset is asynchronous and active low; it clears the control state and sets the vertex
// count to 16. The matrix store is not cleared: every entry in use must be written first.
module prim_minimum_spanning_tree_unit
    import pmst_pkg::*;
#(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_BITS  = 16
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_we,
    input  logic [VC_W-1:0]     cfg_wdata,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ROW_W-1:0]    row,
    input  logic [ROW_W-1:0]    col,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic                last_entry,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [ROW_W-1:0]    from_vertex,
    output logic [ROW_W-1:0]    to_vertex,
    output logic [WEIGHT_W-1:0] edge_weight,
    output logic [TOTAL_W-1:0]  total_cost,
    output logic                is_total,
    output logic                disconnected,
    output logic                last
);

    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int KW     = WEIGHT_BITS + 1;
    localparam int NV_CAP = (MAX_VERTICES < VTX_LIMIT) ? MAX_VERTICES : VTX_LIMIT;
    localparam int SUM_W  = ((WEIGHT_BITS > TOTAL_W) ? WEIGHT_BITS : TOTAL_W) + 1;

    // A key of all zeros below a single top bit stands for "no edge seen yet".
    localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

    // Sequencer and counters.
    state_t               state_reg, state_next;
    logic [VC_W-1:0]      vc_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [CNT_W-1:0]     cnt_reg;

    // Search state.
    logic [KW-1:0]        best_reg;
    logic [IDX_W-1:0]     u_reg;
    logic                 found_reg;
    logic [MAX_VERTICES-1:0] in_tree_reg;
    logic [MAX_VERTICES-1:0] reached_reg;
    logic [KW-1:0]        best_key_reg [MAX_VERTICES];
    logic [IDX_W-1:0]     parent_reg   [MAX_VERTICES];
    logic [TOTAL_W-1:0]   total_reg;
    logic                 disc_reg;

    // Output register.
    logic                 out_valid_reg;
    logic [ROW_W-1:0]     from_reg;
    logic [ROW_W-1:0]     to_reg;
    logic [WEIGHT_W-1:0]  ew_reg;
    logic [TOTAL_W-1:0]   tc_reg;
    logic                 is_total_reg;
    logic                 disc_out_reg;
    logic                 last_reg;

    // Control and datapath signals.
    logic                 in_accept;
    logic                 out_free;
    logic                 out_load;
    logic                 entry_ok;
    logic                 last_cnt;
    logic [IDX_W-1:0]     cidx;
    ram_ctrl_t            ram_ctrl;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic [WEIGHT_BITS-1:0] wr_data;
    logic [WEIGHT_BITS-1:0] rd_data;
    logic [KW-1:0]        cmp_a;
    logic [KW-1:0]        cmp_b;
    logic                 cmp_lt;
    logic [SUM_W-1:0]     sum_wide;
    logic [TOTAL_W-1:0]   sum_sat;
    logic [CNT_W-1:0]     n_used;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cidx      = IDX_W'(cnt_reg);
    assign last_cnt  = (cnt_reg == (n_reg - CNT_W'(1)));

    // A new output word is loaded whenever the sequencer offers one and the register is free.
    assign out_load  = out_free && ((state_reg == ST_EM_ADD) || (state_reg == ST_SUM));

    // Entries whose row or column lies outside the store are dropped.
    assign entry_ok = (32'(row) < MAX_VERTICES) && (32'(col) < MAX_VERTICES);
    assign wr_addr  = {IDX_W'(row), IDX_W'(col)};
    assign wr_data  = WEIGHT_BITS'(weight);

    // A count of zero means one vertex; large counts saturate at the storage size.
    always_comb
    begin
        if (vc_reg == '0)
        begin
            n_used = CNT_W'(1);
        end
        else if (vc_reg > VC_W'(NV_CAP))
        begin
            n_used = CNT_W'(NV_CAP);
        end
        else
        begin
            n_used = CNT_W'(vc_reg);
        end
    end

    // The one comparator, shared by the minimum search and the key relaxation.
    assign cmp_lt = (cmp_a < cmp_b);

    // Saturating running total.
    assign sum_wide = SUM_W'(total_reg) + SUM_W'(rd_data);
    assign sum_sat  = (sum_wide > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum_wide);

    pmst_matrix_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (WEIGHT_BITS)
    ) u_matrix (
        .clk     (clk),
        .ctrl    (ram_ctrl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_accept && last_entry)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                state_next = ST_SEL;
            end
            ST_SEL:
            begin
                if (last_cnt)
                begin
                    state_next = ST_TAKE;
                end
            end
            ST_TAKE:
            begin
                state_next = found_reg ? ST_REL_RD : ST_EM_CHK;
            end
            ST_REL_RD:
            begin
                state_next = ST_REL_UPD;
            end
            ST_REL_UPD:
            begin
                state_next = last_cnt ? ST_SEL : ST_REL_RD;
            end
            ST_EM_CHK:
            begin
                if (cnt_reg >= n_reg)
                begin
                    state_next = ST_SUM;
                end
                else if (reached_reg[cidx])
                begin
                    state_next = ST_EM_ADD;
                end
            end
            ST_EM_ADD:
            begin
                if (out_free)
                begin
                    state_next = ST_EM_CHK;
                end
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Strobes, memory addresses and comparator operands.
    always_comb
    begin
        in_stall       = (state_reg != ST_LOAD);
        ram_ctrl.wr_en = in_accept && entry_ok;
        ram_ctrl.rd_en = 1'b0;
        rd_addr        = {u_reg, cidx};
        cmp_a          = best_key_reg[cidx];
        cmp_b          = best_reg;
        case (state_reg)
            ST_REL_RD:
            begin
                ram_ctrl.rd_en = 1'b1;
            end
            ST_REL_UPD:
            begin
                cmp_a = KW'(rd_data);
                cmp_b = best_key_reg[cidx];
            end
            ST_EM_CHK:
            begin
                // The edge weight is read back as matrix[child][parent].
                ram_ctrl.rd_en = (cnt_reg < n_reg) && reached_reg[cidx];
                rd_addr        = {cidx, parent_reg[cidx]};
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            vc_reg        <= VC_RESET;
            n_reg         <= CNT_W'(VTX_LIMIT);
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            in_tree_reg   <= '0;
            reached_reg   <= '0;
            total_reg     <= '0;
            disc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                vc_reg <= cfg_wdata;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_INIT:
                begin
                    n_reg       <= n_used;
                    cnt_reg     <= '0;
                    found_reg   <= 1'b0;
                    in_tree_reg <= '0;
                    reached_reg <= '0;
                    total_reg   <= '0;
                    disc_reg    <= 1'b0;
                end
                ST_SEL:
                begin
                    if (!in_tree_reg[cidx] && cmp_lt)
                    begin
                        found_reg <= 1'b1;
                    end
                    cnt_reg <= last_cnt ? '0 : cnt_reg + CNT_W'(1);
                end
                ST_TAKE:
                begin
                    if (found_reg)
                    begin
                        in_tree_reg[u_reg] <= 1'b1;
                        reached_reg[u_reg] <= 1'b1;
                        cnt_reg            <= '0;
                    end
                    else
                    begin
                        cnt_reg <= CNT_W'(1);
                    end
                end
                ST_REL_UPD:
                begin
                    if (last_cnt)
                    begin
                        cnt_reg   <= '0;
                        found_reg <= 1'b0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_EM_CHK:
                begin
                    if ((cnt_reg < n_reg) && !reached_reg[cidx])
                    begin
                        disc_reg <= 1'b1;
                        cnt_reg  <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_EM_ADD:
                begin
                    if (out_free)
                    begin
                        total_reg <= sum_sat;
                        cnt_reg   <= cnt_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Search and output payload registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_INIT:
            begin
                best_reg <= KEY_INF;
                for (int k = 0; k < MAX_VERTICES; k++)
                begin
                    best_key_reg[k] <= (k == 0) ? '0 : KEY_INF;
                    parent_reg[k]   <= '0;
                end
            end
            ST_SEL:
            begin
                // Strict compare keeps the lowest index on a tie.
                if (!in_tree_reg[cidx] && cmp_lt)
                begin
                    best_reg <= best_key_reg[cidx];
                    u_reg    <= cidx;
                end
            end
            ST_REL_UPD:
            begin
                if ((rd_data != '0) && !in_tree_reg[cidx] && cmp_lt)
                begin
                    best_key_reg[cidx] <= KW'(rd_data);
                    parent_reg[cidx]   <= u_reg;
                end
                if (last_cnt)
                begin
                    best_reg <= KEY_INF;
                end
            end
            ST_EM_ADD:
            begin
                if (out_free)
                begin
                    from_reg     <= ROW_W'(parent_reg[cidx]);
                    to_reg       <= ROW_W'(cnt_reg);
                    ew_reg       <= WEIGHT_W'(rd_data);
                    tc_reg       <= sum_sat;
                    is_total_reg <= 1'b0;
                    disc_out_reg <= 1'b0;
                    last_reg     <= 1'b0;
                end
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    from_reg     <= '0;
                    to_reg       <= '0;
                    ew_reg       <= '0;
                    tc_reg       <= total_reg;
                    is_total_reg <= 1'b1;
                    disc_out_reg <= disc_reg;
                    last_reg     <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign from_vertex  = from_reg;
    assign to_vertex    = to_reg;
    assign edge_weight  = ew_reg;
    assign total_cost   = tc_reg;
    assign is_total     = is_total_reg;
    assign disconnected = disc_out_reg;
    assign last         = last_reg;

`ifndef NO_ASSERTIONS
    // The tree never holds more vertices than the run uses.
    a_tree_size: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(in_tree_reg) <= 32'(n_reg))
        else $error("tree holds more vertices than the vertex count");

    // Every edge word names a child that the search actually reached.
    a_child_reached: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !is_total_reg) |-> reached_reg[IDX_W'(to_reg)])
        else $error("edge word for an unreached vertex");

    // The running total never falls once an edge word has been taken.
    a_total_rises: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !is_total_reg) |=> total_reg >= $past(total_reg))
        else $error("running total decreased");
`endif

endmodule

FILE: tb/pmst_tree_checker.sv
// Checker for the Prim spanning tree unit: predicts the edge list and compares each output word.
module pmst_tree_checker
    import pmst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [VC_W-1:0]     cfg_wdata,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [ROW_W-1:0]    row,
    input  logic [ROW_W-1:0]    col,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic                last_entry,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [ROW_W-1:0]    from_vertex,
    input  logic [ROW_W-1:0]    to_vertex,
    input  logic [WEIGHT_W-1:0] edge_weight,
    input  logic [TOTAL_W-1:0]  total_cost,
    input  logic                is_total,
    input  logic                disconnected,
    input  logic                last,
    output int                  mismatches,
    output int                  words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          VTX       = 16;
    localparam logic [16:0] KEY_NONE  = 17'h10000;

    typedef struct packed {
        logic [ROW_W-1:0]    from_v;
        logic [ROW_W-1:0]    to_v;
        logic [WEIGHT_W-1:0] edge_w;
        logic [TOTAL_W-1:0]  total;
        logic                is_sum;
        logic                cut_off;
        logic                final_w;
    } tree_word_t;

    logic [WEIGHT_W-1:0] adj_matrix [VTX][VTX];
    logic [VC_W-1:0]     vtx_count;
    tree_word_t          tree_words_q [$];
    int                  mismatch_count;
    int                  words_checked;

    // Grows the tree from vertex 0 over the matrix as it stands and queues the edge list
    // followed by the summary word.
    function automatic void grow_tree();
        logic [16:0]      key [VTX];
        logic [ROW_W-1:0] parent [VTX];
        logic             joined [VTX];
        logic [16:0]      best;
        int               n;
        int               u;
        int               total;
        logic             cut;
        tree_word_t       w;
        n = (vtx_count == 0) ? 1 : ((vtx_count > VTX_LIMIT) ? VTX_LIMIT : int'(vtx_count));
        for (int v = 0; v < VTX; v++)
        begin
            key[v]    = KEY_NONE;
            parent[v] = '0;
            joined[v] = 1'b0;
        end
        key[0] = '0;
        for (int s = 0; s < n; s++)
        begin
            best = KEY_NONE;
            u    = -1;
            // Strict compare keeps the lowest index on a tie.
            for (int v = 0; v < n; v++)
                if (!joined[v] && key[v] < best)
                begin
                    best = key[v];
                    u    = v;
                end
            if (u < 0)
                break;
            joined[u] = 1'b1;
            for (int v = 0; v < n; v++)
                if (adj_matrix[u][v] != '0 && !joined[v] && {1'b0, adj_matrix[u][v]} < key[v])
                begin
                    parent[v] = ROW_W'(u);
                    key[v]    = {1'b0, adj_matrix[u][v]};
                end
        end
        total = 0;
        cut   = 1'b0;
        for (int v = 1; v < n; v++)
        begin
            if (!joined[v])
            begin
                cut = 1'b1;
                continue;
            end
            // The reported weight is read in the reverse direction from the key.
            w.edge_w  = adj_matrix[v][parent[v]];
            total     = total + int'(w.edge_w);
            if (total > int'(TOTAL_MAX))
                total = int'(TOTAL_MAX);
            w.from_v  = parent[v];
            w.to_v    = ROW_W'(v);
            w.total   = TOTAL_W'(total);
            w.is_sum  = 1'b0;
            w.cut_off = 1'b0;
            w.final_w = 1'b0;
            tree_words_q.push_back(w);
        end
        w = '{from_v: '0, to_v: '0, edge_w: '0, total: TOTAL_W'(total),
              is_sum: 1'b1, cut_off: cut, final_w: 1'b1};
        tree_words_q.push_back(w);
    endfunction

    // Prints one line for the mismatch and counts it.
    task automatic flag_mismatch(string what);
        mismatch_count++;
        $display("MISMATCH at %0t ns, result word %0d: %s", $time, words_checked, what);
    endtask

    task automatic check_field(string field, int got, int want);
        if (got != want)
            flag_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tree_word_t exp_w;
        if (!rst_n)
        begin
            vtx_count      = VC_RESET;
            mismatch_count = 0;
            words_checked  = 0;
            tree_words_q.delete();
            mismatches     <= 0;
            words_due      <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                words_checked++;
                if (tree_words_q.size() == 0)
                    flag_mismatch($sformatf("word to vertex %0d with nothing expected",
                                            to_vertex));
                else
                begin
                    exp_w = tree_words_q.pop_front();
                    check_field("from_vertex", from_vertex, exp_w.from_v);
                    check_field("to_vertex", to_vertex, exp_w.to_v);
                    check_field("edge_weight", edge_weight, exp_w.edge_w);
                    check_field("total_cost", total_cost, exp_w.total);
                    check_field("is_total", is_total, exp_w.is_sum);
                    check_field("disconnected", disconnected, exp_w.cut_off);
                    check_field("last", last, exp_w.final_w);
                end
            end
            if (cfg_we)
                vtx_count = cfg_wdata;
            if (in_valid && !in_stall)
            begin
                adj_matrix[row][col] = weight;
                if (last_entry)
                    grow_tree();
            end
            mismatches <= mismatch_count;
            words_due  <= tree_words_q.size();
        end
    end

endmodule

FILE: tb/tb_prim_minimum_spanning_tree_unit.sv
// Testbench top for the Prim spanning tree unit: stimulus, handshake pacing and the verdict.
module tb_prim_minimum_spanning_tree_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pmst_pkg::*;

    // Run length guards. The limit allows every matrix word sent with the longest gaps,
    // every search pass of the unit, every result word waiting out the longest stall and
    // the one long hold, many times over.
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_WORDS  = 75;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int END_CYCLES    = 40;

    // One matrix word as the sender holds it before it goes onto the input channel.
    typedef struct packed {
        logic [ROW_W-1:0]    src;
        logic [ROW_W-1:0]    dst;
        logic [WEIGHT_W-1:0] wt;
        logic                final_entry;
    } matrix_word_t;

    // Every input of the unit starts at a known value.
    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                cfg_we     = 1'b0;
    logic [VC_W-1:0]     cfg_wdata  = '0;
    logic                in_valid   = 1'b0;
    logic [ROW_W-1:0]    row        = '0;
    logic [ROW_W-1:0]    col        = '0;
    logic [WEIGHT_W-1:0] weight     = '0;
    logic                last_entry = 1'b0;
    logic                out_stall  = 1'b0;

    logic                in_stall;
    logic                out_valid;
    logic [ROW_W-1:0]    from_vertex;
    logic [ROW_W-1:0]    to_vertex;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [TOTAL_W-1:0]  total_cost;
    logic                is_total;
    logic                disconnected;
    logic                last;

    int                  mismatches;
    int                  words_due;

    // Sender bookkeeping. The matrix store is not cleared by reset, so the sender remembers
    // which entries have ever been written, and queue_graph writes the missing ones of the
    // vertex range in use along with the word that starts a run.
    matrix_word_t        matrix_words_q [$];
    bit                  entry_loaded [16][16];
    logic [VC_W-1:0]     vc_setting   = VC_RESET;
    bit                  tx_pace      = 1'b1;
    bit                  rx_pace      = 1'b1;
    bit                  hold_request = 1'b0;
    int                  graphs_run   = 0;
    int                  words_in     = 0;
    int                  words_out    = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    prim_minimum_spanning_tree_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .row          (row),
        .col          (col),
        .weight       (weight),
        .last_entry   (last_entry),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .from_vertex  (from_vertex),
        .to_vertex    (to_vertex),
        .edge_weight  (edge_weight),
        .total_cost   (total_cost),
        .is_total     (is_total),
        .disconnected (disconnected),
        .last         (last)
    );

    // The checker watches both channels and the configuration port from the outside.
    pmst_tree_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .row          (row),
        .col          (col),
        .weight       (weight),
        .last_entry   (last_entry),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .from_vertex  (from_vertex),
        .to_vertex    (to_vertex),
        .edge_weight  (edge_weight),
        .total_cost   (total_cost),
        .is_total     (is_total),
        .disconnected (disconnected),
        .last         (last),
        .mismatches   (mismatches),
        .words_due    (words_due)
    );

    // Weights lean towards the interesting values: no edge, small weights that produce ties,
    // and the largest weight, with the rest spread over the full range.
    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0, 1, 2: return '0;
            3, 4:    return WEIGHT_W'($urandom_range(1, 3));
            5:       return '1;
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    task automatic queue_entry(int r, int c, logic [WEIGHT_W-1:0] w);
        matrix_words_q.push_back('{src: ROW_W'(r), dst: ROW_W'(c), wt: w, final_entry: 1'b0});
        entry_loaded[r][c] = 1'b1;
    endtask

    // Builds one matrix for n vertices: every entry never written before, a few random
    // rewrites of older ones, and sometimes stray writes anywhere in the store. The words are
    // shuffled so that the one carrying last_entry can be any entry, in range or not.
    task automatic queue_graph(int n);
        matrix_word_t tmp;
        int           j;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                if (!entry_loaded[r][c] || $urandom_range(0, n * n) < 4)
                    queue_entry(r, c, pick_weight());
        repeat ($urandom_range(0, 2))
            queue_entry($urandom_range(0, 15), $urandom_range(0, 15), pick_weight());
        if (matrix_words_q.size() == 0)
            queue_entry(0, 0, pick_weight());
        for (int i = matrix_words_q.size() - 1; i > 0; i--)
        begin
            j                 = $urandom_range(0, i);
            tmp               = matrix_words_q[i];
            matrix_words_q[i] = matrix_words_q[j];
            matrix_words_q[j] = tmp;
        end
    endtask

    // Sends the queued matrix, marking its final word as the one that starts the run.
    // Valid is left high after the last acceptance; whoever pauses next lowers it.
    task automatic send_queued();
        matrix_word_t word;
        int           gap;
        word = matrix_words_q.pop_back();
        word.final_entry = 1'b1;
        matrix_words_q.push_back(word);
        graphs_run++;
        while (matrix_words_q.size() != 0)
        begin
            word = matrix_words_q.pop_front();
            gap  = tx_pace ? $urandom_range(0, 19) : 0;
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid   <= 1'b1;
            row        <= word.src;
            col        <= word.dst;
            weight     <= word.wt;
            last_entry <= word.final_entry;
            do
                @(posedge clk);
            while (in_stall);
            words_in++;
        end
    endtask

    // Holds the sender back until every expected word has come out, then lets the unit
    // settle. The checker's count is registered, hence the wait on the clock before looking at it.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called once the unit is idle.
    task automatic program_vertex_count(logic [VC_W-1:0] value);
        cfg_we     <= 1'b1;
        cfg_wdata  <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        vc_setting  = value;
    endtask

    // Receiver: before each word it draws a random stall, and in some stretches none at
    // all. When the sender asks for it, it instead holds off for one long stretch so
    // that the unit fills up behind the output and stalls its input.
    initial
    begin : receiver
        int pause;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                pause        = HOLD_CYCLES;
            end
            else
                pause = rx_pace ? $urandom_range(0, 19) : 0;
            if (pause != 0)
            begin
                out_stall <= 1'b1;
                repeat (pause) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!out_valid);
            words_out++;
            if (words_out % 16 == 0)
                rx_pace = ($urandom_range(0, 3) != 0);
        end
    end

    // Watchdog: a stuck handshake ends the run here.
    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int              random_start;
        int              graph_no;
        int              n;
        logic [VC_W-1:0] pick;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A single vertex gives only the summary word with a zero total.
        program_vertex_count(5'd1);
        queue_entry(0, 0, 16'h1234);
        send_queued();
        wait_idle();

        // A count of zero behaves as a single vertex; the run is started by a stray write
        // to the far corner of the store with the largest weight.
        program_vertex_count(5'd0);
        queue_entry(0, 0, 16'h0000);
        queue_entry(15, 15, 16'hFFFF);
        send_queued();
        wait_idle();

        // Two vertices joined by the largest weight in both directions, sent back to back.
        program_vertex_count(5'd2);
        tx_pace = 1'b0;
        queue_entry(0, 0, 16'h0000);
        queue_entry(0, 1, 16'hFFFF);
        queue_entry(1, 0, 16'hFFFF);
        queue_entry(1, 1, 16'h0000);
        send_queued();

        // Straight on with an asymmetric pair: only the reverse direction has an edge, so
        // vertex 1 cannot be reached and the summary word must flag it.
        tx_pace = 1'b1;
        queue_entry(0, 1, 16'h0000);
        queue_entry(1, 0, 16'h0007);
        send_queued();
        wait_idle();

        // Three vertices with a tie on the pick after vertex 0 (the lower index wins) and weights
        // that differ by direction, so a reported weight is not the key that chose its edge.
        program_vertex_count(5'd3);
        queue_entry(0, 0, 16'd0);
        queue_entry(0, 1, 16'd5);
        queue_entry(0, 2, 16'd5);
        queue_entry(1, 0, 16'd9);
        queue_entry(1, 1, 16'd0);
        queue_entry(1, 2, 16'd3);
        queue_entry(2, 0, 16'd8);
        queue_entry(2, 1, 16'd3);
        queue_entry(2, 2, 16'd0);
        send_queued();
        wait_idle();

        // Random part: small graphs with random content, random vertex counts between
        // phases, and some runs started while the previous edge list is still going out.
        random_start = words_in;
        graph_no     = 0;
        while ((words_in - random_start < RANDOM_WORDS) || (graph_no < 4))
        begin
            graph_no++;
            if (graph_no == 4)
            begin
                // Long hold on the output while two matrices follow one another without a
                // pause, so that the unit backs up and stalls its input.
                wait_idle();
                program_vertex_count(5'd5);
                tx_pace      = 1'b0;
                hold_request = 1'b1;
                queue_graph(5);
                send_queued();
                queue_graph(5);
                send_queued();
                wait_idle();
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    wait_idle();
                    pick = ($urandom_range(0, 7) == 0) ? 5'd0 : VC_W'($urandom_range(1, 6));
                    program_vertex_count(pick);
                end
                tx_pace = ($urandom_range(0, 3) != 0);
                n       = (vc_setting == 0) ? 1 : int'(vc_setting);
                queue_graph(n);
                send_queued();
                if ($urandom_range(0, 2) != 0)
                    wait_idle();
            end
        end

        // Largest vertex range last, with a count above the maximum that must saturate to
        // sixteen. Only rows 0 and 15 are read: vertex 0 reaches vertex 15 alone, by a key
        // that differs from the reported weight, and vertices 1 to 14 stay unreachable.
        wait_idle();
        tx_pace = 1'b1;
        program_vertex_count(5'd31);
        for (int c = 0; c < 16; c++)
        begin
            queue_entry(0, c, (c == 15) ? 16'd40 : 16'd0);
            queue_entry(15, c, (c == 0) ? 16'd25 : 16'd0);
        end
        send_queued();
        wait_idle();

        // The same store with a count just above the maximum, restarted by one rewrite of
        // the reported weight to the largest value.
        program_vertex_count(5'd17);
        tx_pace = 1'b0;
        queue_entry(15, 0, 16'hFFFF);
        send_queued();
        wait_idle();

        repeat (END_CYCLES) @(posedge clk);

        $display("Run covered %0d graphs with vertex counts from 0 to 31 programmed,",
                 graphs_run);
        $display("%0d matrix words in, %0d result words out, one output hold of %0d cycles.",
                 words_in, words_out, HOLD_CYCLES);
        if (words_due != 0)
            $display("%0d result words never arrived.", words_due);
        if (mismatches == 0 && words_due == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
